// ===== rtl/esdl_pkg.sv =====
// ---------------------------------------------------------------------------
// esdl_pkg: shared types, constants and microcode for the dither limiter
// Fixed-point constants, control word layout and the sequencer program.
// ---------------------------------------------------------------------------
package esdl_pkg;

    localparam int STEP_W = 3;

    localparam logic [24:0] ENV_ONE   = 25'd16777216;
    localparam logic [21:0] ATK_NEW   = 22'd1677722;
    localparam logic [21:0] REL_NEW   = 22'd16777;
    localparam logic [21:0] LCG_MUL   = 22'd214013;
    localparam logic [31:0] LCG_ADD   = 32'd2531011;
    localparam logic signed [17:0] LIMIT_Q15 = 18'sd32112;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DITHER     = 2'd0;
    localparam logic [1:0] REG_SCRAMBLE   = 2'd1;
    localparam logic [1:0] REG_ENV_ENABLE = 2'd2;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ENV,
        MUL_LCG,
        MUL_AMP,
        MUL_NOISE
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_ENV,
        WB_SEED,
        WB_AMP,
        WB_OUT
    } wb_sel_t;

    // conditional jump back to target; the step's actions are skipped when taken
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_REQ,
        HOLD_OUT_BUSY
    } hold_t;

    typedef struct packed {
        logic               take_in;
        mul_sel_t           mul_sel;
        wb_sel_t            wb_sel;
        hold_t              hold;
        logic [STEP_W-1:0]  target;
        logic               last;
    } ucode_t;

    localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_OUT  = 3'd6;

    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t cw;
        cw = '{take_in: 1'b0, mul_sel: MUL_NONE, wb_sel: WB_NONE,
               hold: HOLD_NONE, target: STEP_IDLE, last: 1'b0};
        case (step)
            3'd0: begin
                cw.take_in = 1'b1;
                cw.hold    = HOLD_NO_REQ;
                cw.target  = STEP_IDLE;
            end
            3'd1: cw.mul_sel = MUL_ENV;
            3'd2: begin
                cw.wb_sel  = WB_ENV;
                cw.mul_sel = MUL_LCG;
            end
            3'd3: begin
                cw.wb_sel  = WB_SEED;
                cw.mul_sel = MUL_AMP;
            end
            3'd4: cw.wb_sel = WB_AMP;
            3'd5: cw.mul_sel = MUL_NOISE;
            3'd6: begin
                cw.wb_sel = WB_OUT;
                cw.hold   = HOLD_OUT_BUSY;
                cw.target = STEP_OUT;
                cw.last   = 1'b1;
            end
            default: begin
                cw.last = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/envelope_shaped_dither_limiter.sv =====
// ---------------------------------------------------------------------------
// envelope_shaped_dither_limiter
// Envelope follower, LCG noise dither scaled by envelope, and +/-0.98 limiter.
// ---------------------------------------------------------------------------
// A sample is taken only when the previous one has finished the program, and
// its result is registered at the last step: a microcoded sequencer runs
// seven steps, and all four products (envelope update, LCG, scramble
// amplitude, noise) go one after another through a single shared 32x22
// multiplier with a registered product; the envelope feeds the amplitude, and
// the LCG and amplitude feed the noise. The next request is taken as soon as
// the sequencer is back at its first step, even while the previous result waits
// in the output register; the last step waits only while that register is occupied.
// Configuration writes are taken at any time but are meant for idle periods.
module envelope_shaped_dither_limiter
    import esdl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_sample_in,

    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_sample_out,
    output logic [24:0]         m_envelope_level
);

    // configuration
    logic [16:0] dither_reg;
    logic [16:0] scramble_reg;
    logic        env_en_reg;

    // state and sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    logic [24:0]       env_reg;
    logic [31:0]       seed_reg;
    logic              m_valid_reg;

    // datapath payload
    logic signed [15:0] sample_reg;
    logic [17:0]        amp_reg;
    logic signed [53:0] prod_reg;
    logic signed [15:0] m_sample_reg;
    logic [24:0]        m_env_reg;

    ucode_t cw;
    logic   hold_taken;
    logic   run;

    assign cw = ucode(step_reg);

    always_comb begin
        case (cw.hold)
            HOLD_NO_REQ:   hold_taken = !s_valid;
            HOLD_OUT_BUSY: hold_taken = m_valid_reg && !m_ready;
            default:       hold_taken = 1'b0;
        endcase
    end

    assign run = !hold_taken;

    always_comb begin
        if (hold_taken) begin
            step_next = cw.target;
        end else if (cw.last) begin
            step_next = STEP_IDLE;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    assign s_ready = cw.take_in;

    // ---------------- datapath ----------------
    logic signed [16:0] s_ext;
    logic signed [16:0] abs_s;
    logic [24:0]        mag;
    logic               attack;
    logic signed [25:0] env_diff;
    logic [24:0]        m_val;
    logic signed [15:0] d_val;

    assign s_ext    = {sample_reg[15], sample_reg};
    assign abs_s    = s_ext[16] ? -s_ext : s_ext;
    assign mag      = {abs_s[15:0], 9'd0};
    assign attack   = mag > env_reg;
    assign env_diff = $signed({1'b0, mag}) - $signed({1'b0, env_reg});
    assign m_val    = env_en_reg ? (ENV_ONE - env_reg) : ENV_ONE;
    assign d_val    = $signed({1'b0, seed_reg[30:16]}) - 16'sd16384;

    logic signed [31:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [53:0] prod_next;

    always_comb begin
        case (cw.mul_sel)
            MUL_ENV: begin
                mul_a = 32'(env_diff);
                mul_b = $signed(attack ? ATK_NEW : REL_NEW);
            end
            MUL_LCG: begin
                // only the low 32 bits are kept, so signedness does not matter
                mul_a = $signed(seed_reg);
                mul_b = $signed(LCG_MUL);
            end
            MUL_AMP: begin
                mul_a = $signed({7'd0, m_val});
                mul_b = $signed({5'd0, scramble_reg});
            end
            MUL_NOISE: begin
                mul_a = 32'(d_val);
                mul_b = $signed({4'd0, amp_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 54'(mul_a) * 54'(mul_b);

    // envelope: env + round((mag - env) * C1 / 2^24), clamped to 1.0
    logic signed [53:0] env_rnd;
    logic signed [29:0] env_sum;
    logic [24:0]        env_new;

    assign env_rnd = prod_reg + 54'sd8388608;
    assign env_sum = $signed({5'd0, env_reg}) + env_rnd[53:24];
    assign env_new = (env_sum > $signed({5'd0, ENV_ONE})) ? ENV_ONE : env_sum[24:0];

    // amplitude: dither + round(scramble * m / 2^25)
    logic signed [53:0] amp_rnd;
    logic [17:0]        amp_new;

    assign amp_rnd = prod_reg + 54'sd16777216;
    assign amp_new = {1'b0, dither_reg} + {1'b0, amp_rnd[41:25]};

    // noise: floor((d * amp + 2^15) / 2^16), then limit
    logic signed [53:0] noise_rnd;
    logic signed [17:0] sum;
    logic signed [15:0] limited;

    assign noise_rnd = prod_reg + 54'sd32768;
    assign sum       = 18'(sample_reg) + 18'($signed(noise_rnd[32:16]));

    always_comb begin
        if (sum > LIMIT_Q15) begin
            limited = LIMIT_Q15[15:0];
        end else if (sum < -LIMIT_Q15) begin
            limited = 16'(-LIMIT_Q15);
        end else begin
            limited = sum[15:0];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_IDLE;
            env_reg      <= '0;
            seed_reg     <= 32'd1;
            m_valid_reg  <= 1'b0;
            dither_reg   <= '0;
            scramble_reg <= '0;
            env_en_reg   <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DITHER:     dither_reg   <= cfg_data;
                    REG_SCRAMBLE:   scramble_reg <= cfg_data;
                    REG_ENV_ENABLE: env_en_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (run && cw.wb_sel == WB_ENV) begin
                env_reg <= env_new;
            end
            if (run && cw.wb_sel == WB_SEED) begin
                seed_reg <= prod_reg[31:0] + LCG_ADD;
            end
            if (run && cw.wb_sel == WB_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample_in;
        end
        if (cw.mul_sel != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        if (run && cw.wb_sel == WB_AMP) begin
            amp_reg <= amp_new;
        end
        if (run && cw.wb_sel == WB_OUT) begin
            m_sample_reg <= limited;
            m_env_reg    <= env_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sample_out     = m_sample_reg;
    assign m_envelope_level = m_env_reg;

    // ---------------- assertions ----------------
    a_env_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= ENV_ONE)
        else $error("envelope above 1.0");

    a_out_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_out <= $signed(LIMIT_Q15[15:0])
                     && m_sample_out >= 16'(-LIMIT_Q15)))
        else $error("result outside limiter range");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (step_reg == 3'd1 && !s_ready))
        else $error("request did not start the program");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_OUT)
        else $error("sequencer left its program");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_sample_out) && $stable(m_envelope_level))
        else $error("pending result overwritten");

endmodule
